[design/pidt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_pkg: shared types and constants for the timed PID controller
// Field widths, payload structs, register indexes and the interfaces
// between the front end, the job queue, the divider and the back end.
// ----------------------------------------------------------------------------
package pidt_pkg;

  // Fixed field widths.
  localparam int SAMPLE_BITS   = 10;
  localparam int TIME_BITS     = 32;
  localparam int GAIN_BITS     = 16;
  localparam int DRIVE_BITS    = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Derived arithmetic widths.
  localparam int ERR_BITS      = SAMPLE_BITS + 1;
  localparam int DIFF_BITS     = ERR_BITS + 1;
  localparam int DIFF_MAG_BITS = DIFF_BITS - 1;
  localparam int DERIV_FRAC    = 8;
  localparam int DIVIDEND_BITS = DIFF_MAG_BITS + DERIV_FRAC;
  localparam int RATE_BITS     = DIVIDEND_BITS + 1;
  localparam int INC_BITS      = ERR_BITS + TIME_BITS + 1;
  localparam int ILIMIT_LOG    = 50;
  localparam int ILIMIT_BITS   = ILIMIT_LOG + 1;
  localparam int SUM_BITS      = 64;

  // Defaults for the top-level parameters.
  localparam int INTEGRAL_BITS_DEFAULT  = 48;
  localparam int GAIN_FRAC_BITS_DEFAULT = 8;

  // Job queue depth.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_LEVEL = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PROP_GAIN    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTEG_GAIN   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DERIV_GAIN   = 2'd3;

  // Configuration reset values.
  localparam logic [SAMPLE_BITS-1:0] TARGET_LEVEL_RESET = 10'd0;
  localparam logic [GAIN_BITS-1:0]   PROP_GAIN_RESET    = 16'd512;
  localparam logic [GAIN_BITS-1:0]   INTEG_GAIN_RESET   = 16'd1280;
  localparam logic [GAIN_BITS-1:0]   DERIV_GAIN_RESET   = 16'd256;

  // Input item.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] measured;
    logic [TIME_BITS-1:0]   now_ms;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [DRIVE_BITS-1:0] drive;
    logic                         clipped;
    logic                         zero_interval;
  } out_item_t;

  // Gains handed to the back end.
  typedef struct packed {
    logic [GAIN_BITS-1:0] prop_gain;
    logic [GAIN_BITS-1:0] integ_gain;
    logic [GAIN_BITS-1:0] deriv_gain;
  } gains_t;

  // One classified job, as the front end leaves it.
  typedef struct packed {
    logic signed [ERR_BITS-1:0] err;
    logic [DIFF_MAG_BITS-1:0]   diff_mag;
    logic                       diff_neg;
    logic [TIME_BITS-1:0]       interval;
    logic                       zero_interval;
  } job_t;

  // Queue write side.
  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  // Queue read side.
  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

  // Divider request and response.
  typedef struct packed {
    logic                     start;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [TIME_BITS-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic [DIVIDEND_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

[design/pid_controller_timed_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_timed_top: timed fixed-point PID controller
// A result passes the front end, the queue and the back end's sequencer states
// before it is registered; the divider is skipped when the interval is zero.
// The back end runs one item at a time; the 19-step derivative divider,
// skipped on a zero interval, sets how soon it can take the next item.
// A two-entry queue lets the input take items while the back end works.
// Synchronous reset restores setpoint and gains and clears the control state.
// ----------------------------------------------------------------------------
module pid_controller_timed_top #(
  parameter int INTEGRAL_BITS  = pidt_pkg::INTEGRAL_BITS_DEFAULT,
  parameter int GAIN_FRAC_BITS = pidt_pkg::GAIN_FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pidt_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pidt_pkg::out_item_t                out_item,
  input  logic                               cfg_write,
  input  logic [pidt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pidt_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import pidt_pkg::*;

  logic [SAMPLE_BITS-1:0] target_level;
  gains_t                 gains;
  q_wr_t                  q_wr;
  q_rd_t                  q_rd;
  logic                   q_ready;
  logic                   q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_level     <= TARGET_LEVEL_RESET;
      gains.prop_gain  <= PROP_GAIN_RESET;
      gains.integ_gain <= INTEG_GAIN_RESET;
      gains.deriv_gain <= DERIV_GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TARGET_LEVEL: target_level     <= cfg_data[SAMPLE_BITS-1:0];
        REG_PROP_GAIN:    gains.prop_gain  <= cfg_data[GAIN_BITS-1:0];
        REG_INTEG_GAIN:   gains.integ_gain <= cfg_data[GAIN_BITS-1:0];
        REG_DERIV_GAIN:   gains.deriv_gain <= cfg_data[GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  pidt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .target_level (target_level),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .q_ready      (q_ready),
    .q_wr         (q_wr)
  );

  pidt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_wr    (q_wr),
    .q_ready (q_ready),
    .q_pop   (q_pop),
    .q_rd    (q_rd)
  );

  pidt_back #(
    .INTEGRAL_BITS  (INTEGRAL_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .gains     (gains),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[design/pidt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_front: input front end of the timed PID controller
// Accepts samples, forms the error, the error change and the interval,
// flags a zero interval and pushes one job per item into the queue.
// ----------------------------------------------------------------------------
module pidt_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [pidt_pkg::SAMPLE_BITS-1:0] target_level,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pidt_pkg::in_item_t               in_item,
  input  logic                             q_ready,
  output pidt_pkg::q_wr_t                  q_wr
);
  import pidt_pkg::*;

  logic signed [ERR_BITS-1:0]  prev_error;
  logic [TIME_BITS-1:0]        prev_time;
  logic signed [ERR_BITS-1:0]  err;
  logic signed [DIFF_BITS-1:0] diff;
  logic [TIME_BITS-1:0]        interval;
  logic                        accept;

  // An item is taken whenever the queue has room.
  assign in_stall = !q_ready;
  assign accept   = in_valid && q_ready;

  // Classify the item against the previous one.
  always_comb begin
    err      = $signed({1'b0, target_level}) - $signed({1'b0, in_item.measured});
    diff     = DIFF_BITS'(err) - DIFF_BITS'(prev_error);
    interval = in_item.now_ms - prev_time;

    q_wr.push              = accept;
    q_wr.job.err           = err;
    q_wr.job.diff_neg      = diff[DIFF_BITS-1];
    q_wr.job.diff_mag      = diff[DIFF_BITS-1] ? DIFF_MAG_BITS'(-diff)
                                               : DIFF_MAG_BITS'(diff);
    q_wr.job.interval      = interval;
    q_wr.job.zero_interval = (interval == '0);
  end

  // Previous error and timestamp follow every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      prev_time  <= '0;
    end else if (accept) begin
      prev_error <= err;
      prev_time  <= in_item.now_ms;
    end
  end

endmodule

[design/pidt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_queue: job queue between front end and back end
// A small first-in first-out buffer that lets the front end keep taking
// items while the back end is still working.
// ----------------------------------------------------------------------------
module pidt_queue (
  input  logic            clk,
  input  logic            rst,
  input  pidt_pkg::q_wr_t q_wr,
  output logic            q_ready,
  input  logic            q_pop,
  output pidt_pkg::q_rd_t q_rd
);
  import pidt_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  job_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign q_ready   = (count != CNT_BITS'(QUEUE_DEPTH));
  assign q_rd.valid = (count != '0);
  assign q_rd.job  = entries[rd_ptr];
  assign do_push   = q_wr.push && q_ready;
  assign do_pop    = q_pop && q_rd.valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_wr.job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/pidt_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_div: restoring divider for the derivative rate
// Divides the scaled error change by the interval, one quotient bit per
// cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pidt_div (
  input  logic               clk,
  input  logic               rst,
  input  pidt_pkg::div_req_t div_req,
  output pidt_pkg::div_rsp_t div_rsp
);
  import pidt_pkg::*;

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic                     busy;
  logic [CNT_BITS-1:0]      count;
  logic [TIME_BITS-1:0]     divisor;
  logic [TIME_BITS-1:0]     rem;
  logic [DIVIDEND_BITS-1:0] work;
  logic [TIME_BITS:0]       trial;
  logic                     fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem, work[DIVIDEND_BITS-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (div_req.start) begin
      busy  <= 1'b1;
      count <= CNT_BITS'(DIVIDEND_BITS);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (div_req.start) begin
      divisor <= div_req.divisor;
      rem     <= '0;
      work    <= div_req.dividend;
    end else if (busy) begin
      rem  <= fits ? TIME_BITS'(trial - {1'b0, divisor}) : TIME_BITS'(trial);
      work <= {work[DIVIDEND_BITS-2:0], fits};
    end
  end

  assign div_rsp.busy     = busy;
  assign div_rsp.quotient = work;

endmodule

[design/pidt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_back: arithmetic back end of the timed PID controller
// Takes jobs from the queue, updates the saturating integral, forms the
// three gain terms, sums and saturates them and holds the result item.
// ----------------------------------------------------------------------------
module pidt_back #(
  parameter int INTEGRAL_BITS  = pidt_pkg::INTEGRAL_BITS_DEFAULT,
  parameter int GAIN_FRAC_BITS = pidt_pkg::GAIN_FRAC_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  pidt_pkg::gains_t    gains,
  input  pidt_pkg::q_rd_t     q_rd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pidt_pkg::out_item_t out_item
);
  import pidt_pkg::*;

  localparam int ACC_BITS   = ((INTEGRAL_BITS > INC_BITS) ? INTEGRAL_BITS : INC_BITS) + 1;
  localparam int PROD_BITS  = INTEGRAL_BITS + GAIN_BITS;
  localparam int CMP_BITS   = (PROD_BITS > ILIMIT_BITS) ? PROD_BITS : ILIMIT_BITS;
  localparam int PPROD_BITS = GAIN_BITS + 1 + ERR_BITS;
  localparam int DPROD_BITS = GAIN_BITS + 1 + RATE_BITS;
  localparam int SHIFT      = GAIN_FRAC_BITS + DERIV_FRAC;

  localparam logic signed [ACC_BITS-1:0] ACC_IMAX =
    {{(ACC_BITS - INTEGRAL_BITS + 1){1'b0}}, {(INTEGRAL_BITS - 1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_IMIN = -ACC_IMAX - 1;
  localparam logic [CMP_BITS-1:0] ILIMIT = CMP_BITS'({1'b1, {ILIMIT_LOG{1'b0}}});
  localparam logic [SUM_BITS-1:0] MAG_NEG_LIMIT =
    SUM_BITS'({1'b1, {(DRIVE_BITS - 1){1'b0}}});
  localparam logic [SUM_BITS-1:0] MAG_POS_LIMIT = SUM_BITS'({(DRIVE_BITS - 1){1'b1}});

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INC   = 3'd1;
  localparam logic [2:0] S_INTEG = 3'd2;
  localparam logic [2:0] S_PROD  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DTERM = 3'd5;
  localparam logic [2:0] S_SUM   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]                      state;
  job_t                            job;
  logic signed [INC_BITS-1:0]      inc;
  logic signed [INTEGRAL_BITS-1:0] integral;
  logic                            clip;
  logic [PROD_BITS-1:0]            imul;
  logic signed [PPROD_BITS-1:0]    pprod;
  logic signed [SUM_BITS-1:0]      iterm;
  logic signed [RATE_BITS-1:0]     rate;
  logic signed [DPROD_BITS-1:0]    dprod;
  logic signed [SUM_BITS-1:0]      sum;

  div_req_t                        div_req;
  div_rsp_t                        div_rsp;

  logic signed [ACC_BITS-1:0]      acc;
  logic                            acc_hi;
  logic                            acc_lo;
  logic [INTEGRAL_BITS-1:0]        imag;
  logic [CMP_BITS-1:0]             imul_ext;
  logic [ILIMIT_BITS-1:0]          ilim;
  logic [SUM_BITS-1:0]             ishift;
  logic signed [SUM_BITS-1:0]      iterm_next;
  logic signed [RATE_BITS-1:0]     rate_next;
  logic [SUM_BITS-1:0]             sum_mag;
  logic [SUM_BITS-1:0]             smag;
  logic                            drive_sat;
  out_item_t                       result;
  logic                            out_free;

  pidt_div u_div (
    .clk     (clk),
    .rst     (rst),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // Pop a job only when idle; the divider starts on the same edge unless the interval is zero.
  always_comb begin
    q_pop            = (state == S_IDLE) && q_rd.valid;
    div_req.start    = q_pop && !q_rd.job.zero_interval;
    div_req.dividend = {q_rd.job.diff_mag, {DERIV_FRAC{1'b0}}};
    div_req.divisor  = q_rd.job.interval;
  end

  // Saturating integral update.
  always_comb begin
    acc    = ACC_BITS'(integral) + ACC_BITS'(inc);
    acc_hi = (acc > ACC_IMAX);
    acc_lo = (acc < ACC_IMIN);
  end

  // Integral term: magnitude times gain, clamped, then signed and scaled.
  always_comb begin
    imag       = integral[INTEGRAL_BITS-1] ? (~integral + 1'b1) : integral;
    imul_ext   = CMP_BITS'(imul);
    ilim       = (imul_ext > ILIMIT) ? ILIMIT_BITS'(ILIMIT) : ILIMIT_BITS'(imul_ext);
    ishift     = SUM_BITS'(ilim) << DERIV_FRAC;
    iterm_next = integral[INTEGRAL_BITS-1] ? -$signed(ishift) : $signed(ishift);
  end

  // Derivative rate from the divider, zero for a zero interval.
  always_comb begin
    if (job.zero_interval) begin
      rate_next = '0;
    end else if (job.diff_neg) begin
      rate_next = -$signed({1'b0, div_rsp.quotient});
    end else begin
      rate_next = $signed({1'b0, div_rsp.quotient});
    end
  end

  // Truncate the sum toward zero and saturate it to the drive range.
  always_comb begin
    sum_mag = sum[SUM_BITS-1] ? (~sum + 1'b1) : sum;
    smag    = sum_mag >> SHIFT;
    if (sum[SUM_BITS-1]) begin
      drive_sat    = (smag > MAG_NEG_LIMIT);
      result.drive = drive_sat ? $signed(DRIVE_BITS'(MAG_NEG_LIMIT))
                               : -$signed(DRIVE_BITS'(smag));
    end else begin
      drive_sat    = (smag > MAG_POS_LIMIT);
      result.drive = drive_sat ? $signed(DRIVE_BITS'(MAG_POS_LIMIT))
                               : $signed(DRIVE_BITS'(smag));
    end
    result.clipped       = clip || drive_sat;
    result.zero_interval = job.zero_interval;
    out_free             = !out_valid || !out_stall;
  end

  // Control sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      integral  <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_rd.valid) begin
            state <= S_INC;
          end
        end
        S_INC: begin
          state <= S_INTEG;
        end
        S_INTEG: begin
          if (acc_hi) begin
            integral <= INTEGRAL_BITS'(ACC_IMAX);
          end else if (acc_lo) begin
            integral <= INTEGRAL_BITS'(ACC_IMIN);
          end else begin
            integral <= INTEGRAL_BITS'(acc);
          end
          state <= S_PROD;
        end
        S_PROD: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (job.zero_interval || !div_rsp.busy) begin
            state <= S_DTERM;
          end
        end
        S_DTERM: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers, loaded by state.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_rd.job;
    end
    if (state == S_INC) begin
      inc <= INC_BITS'($signed({1'b0, job.interval})) * INC_BITS'(job.err);
    end
    if (state == S_INTEG) begin
      clip <= acc_hi || acc_lo;
    end
    if (state == S_PROD) begin
      imul  <= PROD_BITS'(imag) * PROD_BITS'(gains.integ_gain);
      pprod <= PPROD_BITS'($signed({1'b0, gains.prop_gain})) * PPROD_BITS'(job.err);
    end
    if (state == S_WAIT) begin
      iterm <= iterm_next;
      rate  <= rate_next;
    end
    if (state == S_DTERM) begin
      dprod <= DPROD_BITS'($signed({1'b0, gains.deriv_gain})) * DPROD_BITS'(rate);
    end
    if (state == S_SUM) begin
      sum <= (SUM_BITS'(pprod) <<< DERIV_FRAC) + iterm + SUM_BITS'(dprod);
    end
    if ((state == S_OUT) && out_free) begin
      out_item <= result;
    end
  end

  // The back end takes no new job while one is in flight.
  assert property (@(posedge clk) disable iff (rst) (state != S_IDLE) |-> !q_pop)
    else $error("job popped while back end busy");

  // The divider is never restarted while it is still working.
  assert property (@(posedge clk) disable iff (rst) div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A zero-interval job never uses the divider.
  assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_rd.job.zero_interval) |=> !div_rsp.busy)
    else $error("divider running for a zero-interval job");

  // A finished result waits while the previous one is stalled.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && out_stall) |=> (state == S_OUT && out_valid))
    else $error("result overwrote a stalled item");

  // Loading a result always makes it visible on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result load did not raise out_valid");

endmodule

[sim/pidt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_checker: result predictor and scoreboard for the timed PID controller
// Watches the configuration port and both item channels, works out each
// control step from its own copy of the gains and loop state, and compares
// every accepted result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pidt_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  pidt_pkg::in_item_t                 in_item,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  pidt_pkg::out_item_t                out_item,
  input  logic                               cfg_write,
  input  logic [pidt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pidt_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                 mismatches,
  output int                                 outstanding,
  output longint                             integral_level,
  output int                                 steps_checked,
  output int                                 clipped_seen,
  output int                                 zero_span_seen
);

  import pidt_pkg::*;

  localparam int INTEG_BITS = INTEGRAL_BITS_DEFAULT;
  localparam int SUM_SHIFT = GAIN_FRAC_BITS_DEFAULT + DERIV_FRAC;
  localparam longint INTEG_MAX = (longint'(1) << (INTEG_BITS - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam longint unsigned ITERM_CAP = 64'd1 << ILIMIT_LOG;
  localparam longint DRIVE_MAX = (longint'(1) << 31) - 1;
  localparam longint DRIVE_MIN = -(longint'(1) << 31);

  // Configuration copy.
  logic [SAMPLE_BITS-1:0] setpoint;
  logic [GAIN_BITS-1:0]   kp;
  logic [GAIN_BITS-1:0]   ki;
  logic [GAIN_BITS-1:0]   kd;

  // Loop state carried from one control step to the next.
  logic signed [ERR_BITS-1:0]   prev_err;
  logic signed [INTEG_BITS-1:0] integ_acc;
  logic [TIME_BITS-1:0]         last_stamp;

  out_item_t drive_q[$];

  assign integral_level = longint'(integ_acc);

  // One control step: updates the loop state and returns the expected result.
  function automatic out_item_t control_step(input in_item_t it);
    logic [TIME_BITS-1:0] span;
    longint err, acc, inc, diff, rate, iterm, pterm, dterm, sum, drv;
    longint unsigned mag, imag, iprod, smag;
    out_item_t res;
    span = it.now_ms - last_stamp;
    err = longint'(setpoint) - longint'(it.measured);
    acc = longint'(integ_acc);
    res.clipped = 1'b0;
    res.zero_interval = (span == '0);

    // Error integral over the interval, held at the signed limits.
    inc = err * longint'(span);
    if (inc > 0 && acc > INTEG_MAX - inc) begin
      acc = INTEG_MAX;
      res.clipped = 1'b1;
    end else if (inc < 0 && acc < INTEG_MIN - inc) begin
      acc = INTEG_MIN;
      res.clipped = 1'b1;
    end else begin
      acc = acc + inc;
    end
    integ_acc = acc[INTEG_BITS-1:0];

    // Rate of change with 8 fraction bits, truncated toward zero.
    rate = 0;
    if (!res.zero_interval) begin
      diff = err - longint'(prev_err);
      mag = (diff < 0) ? -diff : diff;
      mag = (mag << DERIV_FRAC) / {32'd0, span};
      rate = (diff < 0) ? -longint'(mag) : longint'(mag);
    end

    // Integral term magnitude is capped; beyond the cap the drive saturates anyway.
    imag = (acc < 0) ? -acc : acc;
    if (ki == '0) begin
      iprod = 0;
    end else if (imag > ITERM_CAP / {48'd0, ki}) begin
      iprod = ITERM_CAP;
    end else begin
      iprod = imag * {48'd0, ki};
    end
    if (iprod > ITERM_CAP) begin
      iprod = ITERM_CAP;
    end
    iterm = longint'(iprod << DERIV_FRAC);
    if (acc < 0) begin
      iterm = -iterm;
    end

    pterm = (longint'(kp) * err) <<< DERIV_FRAC;
    dterm = longint'(kd) * rate;
    sum = pterm + iterm + dterm;

    // Drop the fraction bits on the magnitude, then saturate to 32 bits.
    smag = (sum < 0) ? -sum : sum;
    smag = smag >> SUM_SHIFT;
    if (sum < 0) begin
      if (smag > 64'd2147483648) begin
        drv = DRIVE_MIN;
        res.clipped = 1'b1;
      end else begin
        drv = -longint'(smag);
      end
    end else begin
      if (smag > 64'd2147483647) begin
        drv = DRIVE_MAX;
        res.clipped = 1'b1;
      end else begin
        drv = longint'(smag);
      end
    end
    res.drive = drv[DRIVE_BITS-1:0];

    prev_err = err[ERR_BITS-1:0];
    last_stamp = it.now_ms;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      setpoint = TARGET_LEVEL_RESET;
      kp = PROP_GAIN_RESET;
      ki = INTEG_GAIN_RESET;
      kd = DERIV_GAIN_RESET;
      prev_err = '0;
      integ_acc = '0;
      last_stamp = '0;
      drive_q.delete();
      mismatches = 0;
      steps_checked = 0;
      clipped_seen = 0;
      zero_span_seen = 0;
    end else begin
      // Register writes are to be made only while the controller is idle; nothing here enforces it.
      if (cfg_write) begin
        case (cfg_index)
          REG_TARGET_LEVEL: setpoint = cfg_data[SAMPLE_BITS-1:0];
          REG_PROP_GAIN:    kp = cfg_data[GAIN_BITS-1:0];
          REG_INTEG_GAIN:   ki = cfg_data[GAIN_BITS-1:0];
          REG_DERIV_GAIN:   kd = cfg_data[GAIN_BITS-1:0];
          default: ;
        endcase
      end

      // Compare an accepted result with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          $error("unexpected result item: drive %0d", out_item.drive);
          mismatches++;
        end else begin
          want = drive_q.pop_front();
          steps_checked++;
          if (want.clipped) clipped_seen++;
          if (want.zero_interval) zero_span_seen++;
          if (out_item.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, out_item.drive);
            mismatches++;
          end
          if (out_item.clipped !== want.clipped) begin
            $error("clipped: expected %0b, got %0b", want.clipped, out_item.clipped);
            mismatches++;
          end
          if (out_item.zero_interval !== want.zero_interval) begin
            $error("zero_interval: expected %0b, got %0b", want.zero_interval,
                   out_item.zero_interval);
            mismatches++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        drive_q.push_back(control_step(in_item));
      end
    end
    outstanding = drive_q.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the timed PID controller
// Runs a directed set of edge cases, then six gain settings with random
// tracking, noise and integral windup traffic under varied idling, while
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  import pidt_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_item;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_item;
  logic                     cfg_write;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int     mismatches;
  int     outstanding;
  longint integral_level;
  int     steps_checked;
  int     clipped_seen;
  int     zero_span_seen;

  int                   tx_pct = 0;
  int                   rx_pct = 0;
  int                   quiet_cycles = 0;
  logic [TIME_BITS-1:0] stamp = '0;

  pid_controller_timed_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pidt_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .integral_level (integral_level),
    .steps_checked  (steps_checked),
    .clipped_seen   (clipped_seen),
    .zero_span_seen (zero_span_seen)
  );

  always #6 clk = ~clk;

  // Result side stalls at random when the phase asks for it.
  always @(negedge clk) begin
    out_stall <= (rx_pct > 0) && ($urandom_range(99) < rx_pct);
  end

  // Watchdog: too long without any item moving ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pid_controller_timed_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, with an optional random gap first, and wait until taken.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] m, input logic [TIME_BITS-1:0] t);
    if (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      while ($urandom_range(99) < tx_pct) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= {m, t};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    stamp = t;
  endtask

  // Stop offering items and wait for every outstanding result.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Interval mix: mostly a control-loop period, some zero, some long.
  function automatic logic [TIME_BITS-1:0] pick_span();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 85) return $urandom_range(150, 1);
    if (r < 95) return $urandom_range(70000, 151);
    return $urandom;
  endfunction

  initial begin
    int ph, count, len, mv, base, k, e;
    logic [SAMPLE_BITS-1:0] tl, m;
    logic [GAIN_BITS-1:0]   kp, ki, kd;
    logic [5:0]             junk;
    longint                 acc;
    longint unsigned        span64;

    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_TARGET_LEVEL;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: first step at time zero, extremes of sample and timestamp,
    // largest error swings over one millisecond, timestamp wrap.
    send_sample(10'd0, 32'd0);
    send_sample(10'd1023, 32'd0);
    send_sample(10'd1023, 32'd1);
    send_sample(10'd0, 32'd2);
    send_sample(10'd1023, 32'd3);
    send_sample(10'd0, 32'hFFFF_FFFF);
    send_sample(10'd0, 32'd0);
    send_sample(10'd1023, 32'h8000_0000);

    // All gains at their maximum, setpoint written with its unused bits set.
    drain();
    write_reg(REG_TARGET_LEVEL, 16'hFFFF);
    write_reg(REG_PROP_GAIN, 16'hFFFF);
    write_reg(REG_INTEG_GAIN, 16'hFFFF);
    write_reg(REG_DERIV_GAIN, 16'hFFFF);
    send_sample(10'd0, stamp + 32'd1);
    send_sample(10'd0, stamp);
    send_sample(10'd1023, stamp + 32'd2);
    send_sample(10'd512, stamp + 32'd3);

    // All gains zero.
    drain();
    write_reg(REG_TARGET_LEVEL, 16'h0000);
    write_reg(REG_PROP_GAIN, 16'h0000);
    write_reg(REG_INTEG_GAIN, 16'h0000);
    write_reg(REG_DERIV_GAIN, 16'h0000);
    send_sample(10'd1023, stamp + 32'd5);
    send_sample(10'd0, stamp + 32'd5);

    for (ph = 0; ph < 6; ph++) begin
      // Bring the integral back near zero with a mid-scale setpoint.
      drain();
      junk = 6'($urandom);
      write_reg(REG_TARGET_LEVEL, {junk, 10'd512});
      for (k = 0; k < 80; k++) begin
        acc = integral_level;
        if (acc > 0) begin
          m = 10'd1023;
          e = 511;
        end else begin
          m = 10'd0;
          e = 512;
        end
        span64 = ((acc < 0) ? -acc : acc) / longint'(e);
        if (span64 == 0) break;
        if (span64 > 64'hFFFF_FFFF) span64 = 64'hFFFF_FFFF;
        send_sample(m, stamp + span64[TIME_BITS-1:0]);
        drain();
      end

      // Gain setting and idling pattern for this phase.
      case (ph)
        0: begin
          tl = 10'd1023; kp = 16'hFFFF; ki = 16'hFFFF; kd = 16'hFFFF;
          tx_pct = 0; rx_pct = 0;
        end
        1: begin
          tl = 10'd0; kp = 16'h0000; ki = 16'h0000; kd = 16'h0000;
          tx_pct = 57; rx_pct = 0;
        end
        2: begin
          tl = SAMPLE_BITS'($urandom); kp = GAIN_BITS'($urandom);
          ki = GAIN_BITS'($urandom); kd = GAIN_BITS'($urandom);
          tx_pct = 0; rx_pct = 57;
        end
        3: begin
          tl = 10'd512; kp = 16'd256; ki = 16'd1; kd = 16'd256;
          tx_pct = 29; rx_pct = 29;
        end
        4: begin
          tl = SAMPLE_BITS'($urandom); kp = GAIN_BITS'($urandom);
          ki = GAIN_BITS'($urandom_range(64)); kd = GAIN_BITS'($urandom);
          tx_pct = 0; rx_pct = 57;
        end
        default: begin
          tl = SAMPLE_BITS'($urandom); kp = GAIN_BITS'($urandom_range(1024));
          ki = GAIN_BITS'($urandom_range(300));
          kd = GAIN_BITS'($urandom); tx_pct = 57; rx_pct = 0;
        end
      endcase
      junk = 6'($urandom);
      write_reg(REG_TARGET_LEVEL, {junk, tl});
      write_reg(REG_PROP_GAIN, kp);
      write_reg(REG_INTEG_GAIN, ki);
      write_reg(REG_DERIV_GAIN, kd);

      // Random episodes: tracking around the setpoint, or raw noise.
      count = 0;
      while (count < 70) begin
        if ($urandom_range(99) < 4) drain();
        if ($urandom_range(99) < 75) begin
          len = $urandom_range(40, 8);
          base = ($urandom_range(1)) ? int'(tl) + int'($urandom_range(128)) - 64
                                     : int'($urandom_range(1023));
          mv = base;
          for (k = 0; k < len; k++) begin
            mv = mv + int'($urandom_range(16)) - 8;
            if (mv < 0) mv = 0;
            if (mv > 1023) mv = 1023;
            send_sample(mv[SAMPLE_BITS-1:0], stamp + pick_span());
          end
        end else begin
          len = $urandom_range(8, 2);
          for (k = 0; k < len; k++) begin
            send_sample(SAMPLE_BITS'($urandom), $urandom);
          end
        end
        count += len;
      end

      // Windup: long intervals with the largest error of one sign drive the
      // integral into its limit.
      m = (tl >= 10'd512) ? 10'd0 : 10'd1023;
      for (k = 0; k < 60; k++) begin
        if ($urandom_range(99) < 5) begin
          send_sample(m, stamp);
        end else begin
          send_sample(m, stamp + $urandom_range(32'hFFFF_FFFF, 32'hE000_0000));
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Checked %0d control steps: directed cases and six gain settings.",
             steps_checked);
    $display("Saturation flagged on %0d steps, zero interval on %0d steps.",
             clipped_seen, zero_span_seen);
    if (mismatches == 0) begin
      $display("pid_controller_timed_top regression: pass");
    end else begin
      $display("pid_controller_timed_top regression: fail");
    end
    $finish;
  end

endmodule
